// File: src/weekday_alarm_matcher_macros.svh
// assertion macros for the weekday alarm matcher
// expects clk and rst_n in the scope where a macro is used
`ifndef WEEKDAY_ALARM_MATCHER_MACROS_SVH
`define WEEKDAY_ALARM_MATCHER_MACROS_SVH

// same-cycle implication
`define WAM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WAM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/wam_pkg.sv
// types, codes and helper functions of the weekday alarm matcher
// no dependencies
`timescale 1ns / 1ps

package wam_pkg;

  localparam int ALARM_SLOTS = 8;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int SLOT_CNT_W  = $clog2(ALARM_SLOTS + 1);
  localparam int RES_MAX     = 3;

  localparam logic [10:0] MIN_PER_HOUR = 11'd60;
  localparam logic [11:0] MIN_PER_DAY  = 12'd1440;
  localparam logic [11:0] MIN_2_DAYS   = 12'd2880;
  localparam logic [3:0]  DAYS_PER_WK  = 4'd7;
  localparam logic [2:0]  DAY_SUN      = 3'd0;
  localparam logic [2:0]  DAY_SAT      = 3'd6;

  localparam logic [5:0] MIN_HOUR    = 6'd0;
  localparam logic [5:0] MIN_QUARTER = 6'd15;
  localparam logic [5:0] MIN_HALF    = 6'd30;
  localparam logic [5:0] MIN_3QUART  = 6'd45;
  localparam logic [5:0] MIN_LIMIT   = 6'd60;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_FADE  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [2:0] SCH_OFF     = 3'd0;
  localparam logic [2:0] SCH_ONCE    = 3'd1;
  localparam logic [2:0] SCH_WORK    = 3'd3;
  localparam logic [2:0] SCH_WEEKEND = 3'd4;

  localparam logic [2:0] ACT_SUNRISE   = 3'd0;
  localparam logic [2:0] ACT_SOUND     = 3'd1;
  localparam logic [2:0] ACT_DUSK      = 3'd2;
  localparam logic [2:0] ACT_CHIME     = 3'd3;
  localparam logic [2:0] ACT_POWER_OFF = 3'd4;

  localparam logic [2:0] CFG_HOUR_TRACK    = 3'd0;
  localparam logic [2:0] CFG_HALF_TRACK    = 3'd1;
  localparam logic [2:0] CFG_QUARTER_TRACK = 3'd2;
  localparam logic [2:0] CFG_FIRST_HOUR    = 3'd3;
  localparam logic [2:0] CFG_LAST_HOUR     = 3'd4;

  localparam logic [4:0] LAST_HOUR_RST = 5'd24;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [2:0]  entry_index;
    logic [2:0]  schedule;
    logic        has_sound;
    logic        sunrise_on;
    logic [10:0] sunrise_lead;
    logic        dusk_on;
    logic        dusk_power_off;
  } wam_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] alarm_slot;
    logic [7:0] chime_track;
    logic       last;
  } wam_out_t;

  typedef struct packed {
    logic [2:0]  schedule;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        has_sound;
    logic        sunrise_on;
    logic [10:0] sunrise_lead;
    logic        dusk_on;
    logic        dusk_power_off;
  } wam_slot_t;

  localparam int SLOT_BITS = $bits(wam_slot_t);

  // minutes since midnight, fits 11 bits for any 5-bit hour and 6-bit minute
  function automatic logic [10:0] time_of_day(input logic [4:0] hour, input logic [5:0] minute);
    time_of_day = 11'(hour) * MIN_PER_HOUR + 11'(minute);
  endfunction

  function automatic logic day_allowed(input logic [2:0] schedule, input logic [2:0] day);
    logic weekend;
    weekend = (day == DAY_SUN) || (day == DAY_SAT);
    if (schedule == SCH_WEEKEND) begin
      day_allowed = weekend;
    end else if (schedule == SCH_WORK) begin
      day_allowed = !weekend;
    end else begin
      day_allowed = 1'b1;
    end
  endfunction

endpackage

// File: src/wam_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module wam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/weekday_alarm_matcher.sv
// top level of the weekday alarm matcher: sequencer, chime logic, config registers
// depends on wam_pkg, wam_ram and weekday_alarm_matcher_macros.svh
`timescale 1ns / 1ps
`include "weekday_alarm_matcher_macros.svh"

// Usage
// in_valid/in_stall/in_data carry one item per transaction: a minute tick, a
// fade-finished event or a write of one alarm slot. out_valid/out_stall/out_data
// return result transactions; the final one of an item has last set.
// cfg_we/cfg_index/cfg_wdata write the chime registers; the user is to do so
// only while the block is idle, which the block itself does not enforce.
// A slot write, a fade event with no power-off pending and a tick with nonzero
// second leave the block idle; a fade event that reports power-off emits one
// result. A tick with second zero walks the slot table through the single read
// port of the table memory, one slot per cycle: an accept step, a scan of
// every slot, a finish step that builds up to 3 results, then those results
// in order, each held on the output while out_stall is high.
// One item is in flight at a time; in_stall is high until its last result
// is taken. A stalled receiver holds the current result and the block waits.
// Reset clears every slot to off through per-slot valid bits, clears the
// pending power-off and loads the chime registers with their reset values;
// no clearing pass is needed, the block accepts items right after reset.

module weekday_alarm_matcher
  import wam_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wam_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wam_out_t out_data,
  input  logic     cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH, ST_EMIT} state_t;

  state_t state_r;

  // config registers
  logic [7:0] hour_track_r, half_track_r, quarter_track_r;
  logic [4:0] first_hour_r, last_hour_r;

  logic                   fade_pending_r;
  logic [ALARM_SLOTS-1:0] valid_r;

  // tick context
  logic [4:0]  tick_hour_r;
  logic [5:0]  tick_minute_r;
  logic [2:0]  day_r;
  logic [10:0] tick_tod_r;

  // walk through the table
  logic [SLOT_CNT_W-1:0] cnt_r;
  logic                  ev_vld_r;
  logic [SLOT_W-1:0]     ev_slot_r;

  logic              sun_found_r;
  logic [SLOT_W-1:0] sun_slot_r;
  logic              main_found_r;
  logic [SLOT_W-1:0] main_slot_r;
  wam_slot_t         main_entry_r;

  // results
  wam_out_t res_r [RES_MAX];
  logic [1:0] res_cnt_r, emit_idx_r;
  logic       out_valid_r;
  wam_out_t   out_data_r;

  // ram ports
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
  logic [SLOT_BITS-1:0] ram_wdata, ram_rdata;

  logic      in_acc, out_acc;
  wam_slot_t in_slot, ev_entry;
  logic      wr_in_range;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_slot = '{schedule: in_data.schedule, hour: in_data.hour,
                     minute: in_data.minute, has_sound: in_data.has_sound,
                     sunrise_on: in_data.sunrise_on, sunrise_lead: in_data.sunrise_lead,
                     dusk_on: in_data.dusk_on, dusk_power_off: in_data.dusk_power_off};
  assign wr_in_range = (int'(in_data.entry_index) < ALARM_SLOTS);

  // write port: slot writes from idle, one-time clear-back after the walk
  always_comb begin
    wam_slot_t wb;
    wb          = main_entry_r;
    wb.schedule = SCH_OFF;
    ram_we      = 1'b0;
    ram_waddr   = SLOT_W'(in_data.entry_index);
    ram_wdata   = in_slot;
    if (state_r == ST_FINISH) begin
      ram_we    = main_found_r && (main_entry_r.schedule == SCH_ONCE);
      ram_waddr = main_slot_r;
      ram_wdata = wb;
    end else if (in_acc && in_data.mode == MODE_WRITE) begin
      ram_we = wr_in_range;
    end
  end

  assign ram_raddr = cnt_r[SLOT_W-1:0];

  wam_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (ALARM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slot that was never written reads as off
  assign ev_entry = valid_r[ev_slot_r] ? wam_slot_t'(ram_rdata) : '0;

  // match checks for the slot whose data is on the read port
  logic [11:0] sun_t, sun_rem;
  logic [3:0]  sun_day_sum, sun_day;
  logic        sun_hit, main_hit, slot_active;

  always_comb begin
    logic [1:0] days;
    sun_t = 12'(tick_tod_r) + 12'(ev_entry.sunrise_lead);
    if (sun_t >= MIN_2_DAYS) begin
      sun_rem = sun_t - MIN_2_DAYS;
      days    = 2'd2;
    end else if (sun_t >= MIN_PER_DAY) begin
      sun_rem = sun_t - MIN_PER_DAY;
      days    = 2'd1;
    end else begin
      sun_rem = sun_t;
      days    = 2'd0;
    end
    sun_day_sum = 4'(day_r) + 4'(days);
    sun_day     = (sun_day_sum >= DAYS_PER_WK) ? sun_day_sum - DAYS_PER_WK : sun_day_sum;
    slot_active = (ev_entry.schedule != SCH_OFF);
    // a valid minute and equal minutes-of-day pin down hour and minute
    sun_hit  = slot_active && ev_entry.sunrise_on && (ev_entry.minute < MIN_LIMIT) &&
               (12'(time_of_day(ev_entry.hour, ev_entry.minute)) == sun_rem) &&
               day_allowed(ev_entry.schedule, sun_day[2:0]);
    main_hit = slot_active && (ev_entry.hour == tick_hour_r) &&
               (ev_entry.minute == tick_minute_r) &&
               day_allowed(ev_entry.schedule, day_r);
  end

  // results of a finished walk
  wam_out_t res_nxt [RES_MAX];
  logic [1:0] res_cnt_nxt;
  logic       fade_nxt;

  always_comb begin
    logic [7:0] track;
    logic       in_window;
    for (int i = 0; i < RES_MAX; i++) begin
      res_nxt[i] = '0;
    end
    res_cnt_nxt = 2'd0;
    fade_nxt    = fade_pending_r;
    track       = 8'd0;
    in_window   = (tick_hour_r >= first_hour_r) && (tick_hour_r <= last_hour_r);
    if (sun_found_r) begin
      res_nxt[res_cnt_nxt] = '{action: ACT_SUNRISE, alarm_slot: 3'(sun_slot_r),
                               chime_track: 8'd0, last: 1'b0};
      res_cnt_nxt = res_cnt_nxt + 2'd1;
    end
    if (main_found_r) begin
      if (main_entry_r.has_sound) begin
        res_nxt[res_cnt_nxt] = '{action: ACT_SOUND, alarm_slot: 3'(main_slot_r),
                                 chime_track: 8'd0, last: 1'b0};
        res_cnt_nxt = res_cnt_nxt + 2'd1;
      end
      if (main_entry_r.dusk_on) begin
        res_nxt[res_cnt_nxt] = '{action: ACT_DUSK, alarm_slot: 3'(main_slot_r),
                                 chime_track: 8'd0, last: 1'b0};
        res_cnt_nxt = res_cnt_nxt + 2'd1;
        fade_nxt    = main_entry_r.dusk_power_off;
      end
    end else if (in_window) begin
      if (hour_track_r != 8'd0 && tick_minute_r == MIN_HOUR) begin
        track = hour_track_r;
      end else if (half_track_r != 8'd0 && tick_minute_r == MIN_HALF) begin
        track = half_track_r;
      end else if (quarter_track_r != 8'd0 &&
                   (tick_minute_r == MIN_QUARTER || tick_minute_r == MIN_3QUART)) begin
        track = quarter_track_r;
      end
      if (track != 8'd0) begin
        res_nxt[res_cnt_nxt] = '{action: ACT_CHIME, alarm_slot: 3'd0,
                                 chime_track: track, last: 1'b0};
        res_cnt_nxt = res_cnt_nxt + 2'd1;
      end
    end
    for (int i = 0; i < RES_MAX; i++) begin
      res_nxt[i].last = (2'(i) + 2'd1 == res_cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      hour_track_r    <= 8'd0;
      half_track_r    <= 8'd0;
      quarter_track_r <= 8'd0;
      first_hour_r    <= 5'd0;
      last_hour_r     <= LAST_HOUR_RST;
      fade_pending_r  <= 1'b0;
      valid_r         <= '0;
      cnt_r           <= '0;
      ev_vld_r        <= 1'b0;
      sun_found_r     <= 1'b0;
      main_found_r    <= 1'b0;
      res_cnt_r       <= 2'd0;
      emit_idx_r      <= 2'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOUR_TRACK:    hour_track_r    <= cfg_wdata;
          CFG_HALF_TRACK:    half_track_r    <= cfg_wdata;
          CFG_QUARTER_TRACK: quarter_track_r <= cfg_wdata;
          CFG_FIRST_HOUR:    first_hour_r    <= cfg_wdata[4:0];
          CFG_LAST_HOUR:     last_hour_r     <= cfg_wdata[4:0];
          default: ;
        endcase
      end

      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end

      ev_vld_r  <= (state_r == ST_SCAN) && (cnt_r < SLOT_CNT_W'(ALARM_SLOTS));
      ev_slot_r <= cnt_r[SLOT_W-1:0];

      if (ev_vld_r) begin
        if (sun_hit && !sun_found_r) begin
          sun_found_r <= 1'b1;
          sun_slot_r  <= ev_slot_r;
        end
        if (main_hit && !main_found_r) begin
          main_found_r <= 1'b1;
          main_slot_r  <= ev_slot_r;
          main_entry_r <= ev_entry;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.mode == MODE_TICK && in_data.second == 6'd0) begin
              tick_hour_r   <= in_data.hour;
              tick_minute_r <= in_data.minute;
              tick_tod_r    <= time_of_day(in_data.hour, in_data.minute);
              day_r         <= (in_data.weekday == 3'd7) ? DAY_SUN : in_data.weekday;
              cnt_r         <= '0;
              sun_found_r   <= 1'b0;
              main_found_r  <= 1'b0;
              state_r       <= ST_SCAN;
            end else if (in_data.mode == MODE_FADE) begin
              fade_pending_r <= 1'b0;
              if (fade_pending_r) begin
                out_data_r  <= '{action: ACT_POWER_OFF, alarm_slot: 3'd0,
                                 chime_track: 8'd0, last: 1'b1};
                out_valid_r <= 1'b1;
                res_cnt_r   <= 2'd1;
                emit_idx_r  <= 2'd1;
                state_r     <= ST_EMIT;
              end
            end
          end
        end
        ST_SCAN: begin
          // last slot is evaluated in the cycle the count reaches the depth
          if (cnt_r == SLOT_CNT_W'(ALARM_SLOTS)) begin
            state_r <= ST_FINISH;
          end else begin
            cnt_r <= cnt_r + SLOT_CNT_W'(1);
          end
        end
        ST_FINISH: begin
          fade_pending_r <= fade_nxt;
          for (int i = 0; i < RES_MAX; i++) begin
            res_r[i] <= res_nxt[i];
          end
          res_cnt_r <= res_cnt_nxt;
          if (res_cnt_nxt == 2'd0) begin
            state_r <= ST_IDLE;
          end else begin
            out_data_r  <= res_nxt[0];
            out_valid_r <= 1'b1;
            emit_idx_r  <= 2'd1;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (emit_idx_r == res_cnt_r) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              out_data_r <= res_r[emit_idx_r];
              emit_idx_r <= emit_idx_r + 2'd1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `WAM_ASSERT_IMP(a_busy_while_result, out_valid, in_stall, "input taken while a result waits")
  `WAM_ASSERT_NXT(a_last_ends_item, out_valid && !out_stall && out_data.last, !out_valid, "result after the last one of an item")
  `WAM_ASSERT_IMP(a_table_write_phase, ram_we, (state_r == ST_IDLE) || (state_r == ST_FINISH), "table written during the walk")
  `WAM_ASSERT_IMP(a_chime_no_slot, out_valid && (out_data.action == ACT_CHIME), (out_data.alarm_slot == 3'd0) && (out_data.chime_track != 8'd0), "chime result with slot or without track")

endmodule

// File: bench/weekday_alarm_matcher_checker.sv
`timescale 1ns / 1ps
// result checker of the weekday alarm matcher: watches the input, result and config ports,
// predicts the actions of every accepted transaction and compares them in order
// depends on wam_pkg

module weekday_alarm_matcher_checker
  import wam_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  wam_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  wam_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         actions_pending,
  output int         actions_checked
);

  localparam int MINUTES_PER_HOUR = 60;
  localparam int MINUTES_PER_DAY  = 1440;
  localparam int WEEK_DAYS        = 7;
  localparam int PRINT_LIMIT      = 40;

  wam_slot_t  alarm_slots [ALARM_SLOTS];
  logic       power_off_armed;
  logic [7:0] hour_track;
  logic [7:0] half_track;
  logic [7:0] quarter_track;
  logic [4:0] first_hour;
  logic [4:0] last_hour;

  wam_out_t expected_actions [$];
  int       mismatch_count = 0;
  int       checked_count  = 0;

  function automatic bit schedule_permits(input logic [2:0] sched, input int day);
    bit weekend;
    weekend = (day == int'(DAY_SUN)) || (day == int'(DAY_SAT));
    if (sched == SCH_WEEKEND) begin
      return weekend;
    end else if (sched == SCH_WORK) begin
      return !weekend;
    end
    return 1'b1;
  endfunction

  function automatic wam_out_t action_result(input logic [2:0] act, input int slot,
                                             input logic [7:0] track);
    wam_out_t r;
    r.action      = act;
    r.alarm_slot  = 3'(slot);
    r.chime_track = track;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic predict_actions(input wam_in_t item);
    wam_out_t acts [RES_MAX];
    int       n;
    int       day;
    int       shifted;
    int       shifted_day;
    bit       found;
    bit       matched;
    n       = 0;
    found   = 1'b0;
    matched = 1'b0;
    day     = int'(item.weekday) % WEEK_DAYS;
    case (item.mode)
      MODE_TICK: begin
        if (item.second == 6'd0) begin
          // sunrise: slot time equals tick time pushed forward by the lead
          for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (!found && alarm_slots[i].schedule != SCH_OFF && alarm_slots[i].sunrise_on) begin
              shifted = int'(item.hour) * MINUTES_PER_HOUR + int'(item.minute)
                        + int'(alarm_slots[i].sunrise_lead);
              shifted_day = (day + shifted / MINUTES_PER_DAY) % WEEK_DAYS;
              shifted = shifted % MINUTES_PER_DAY;
              if (shifted / MINUTES_PER_HOUR == int'(alarm_slots[i].hour) &&
                  shifted % MINUTES_PER_HOUR == int'(alarm_slots[i].minute) &&
                  schedule_permits(alarm_slots[i].schedule, shifted_day)) begin
                acts[n] = action_result(ACT_SUNRISE, i, 8'd0);
                n++;
                found = 1'b1;
              end
            end
          end
          for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (!matched && alarm_slots[i].schedule != SCH_OFF &&
                item.hour == alarm_slots[i].hour && item.minute == alarm_slots[i].minute &&
                schedule_permits(alarm_slots[i].schedule, day)) begin
              matched = 1'b1;
              if (alarm_slots[i].has_sound) begin
                acts[n] = action_result(ACT_SOUND, i, 8'd0);
                n++;
              end
              if (alarm_slots[i].dusk_on) begin
                acts[n] = action_result(ACT_DUSK, i, 8'd0);
                n++;
                power_off_armed = alarm_slots[i].dusk_power_off;
              end
              if (alarm_slots[i].schedule == SCH_ONCE) begin
                alarm_slots[i].schedule = SCH_OFF;
              end
            end
          end
          if (!matched && item.hour >= first_hour && item.hour <= last_hour) begin
            if (hour_track != 8'd0 && item.minute == MIN_HOUR) begin
              acts[n] = action_result(ACT_CHIME, 0, hour_track);
              n++;
            end else if (half_track != 8'd0 && item.minute == MIN_HALF) begin
              acts[n] = action_result(ACT_CHIME, 0, half_track);
              n++;
            end else if (quarter_track != 8'd0 &&
                         (item.minute == MIN_QUARTER || item.minute == MIN_3QUART)) begin
              acts[n] = action_result(ACT_CHIME, 0, quarter_track);
              n++;
            end
          end
        end
      end
      MODE_FADE: begin
        if (power_off_armed) begin
          acts[n] = action_result(ACT_POWER_OFF, 0, 8'd0);
          n++;
        end
        power_off_armed = 1'b0;
      end
      MODE_WRITE: begin
        if (int'(item.entry_index) < ALARM_SLOTS) begin
          alarm_slots[item.entry_index].schedule       = item.schedule;
          alarm_slots[item.entry_index].hour           = item.hour;
          alarm_slots[item.entry_index].minute         = item.minute;
          alarm_slots[item.entry_index].has_sound      = item.has_sound;
          alarm_slots[item.entry_index].sunrise_on     = item.sunrise_on;
          alarm_slots[item.entry_index].sunrise_lead   = item.sunrise_lead;
          alarm_slots[item.entry_index].dusk_on        = item.dusk_on;
          alarm_slots[item.entry_index].dusk_power_off = item.dusk_power_off;
        end
      end
      default: begin
      end
    endcase
    if (n > 0) begin
      acts[n-1].last = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      expected_actions.push_back(acts[k]);
    end
  endtask

  task automatic compare_action(input wam_out_t got);
    wam_out_t want;
    if (expected_actions.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: action %0d slot %0d track %0d last %0d",
                                got.action, got.alarm_slot, got.chime_track, got.last));
    end else begin
      want = expected_actions.pop_front();
      checked_count++;
      if (got.action !== want.action) begin
        report_mismatch($sformatf("action got %0d want %0d", got.action, want.action));
      end
      if (got.alarm_slot !== want.alarm_slot) begin
        report_mismatch($sformatf("alarm_slot got %0d want %0d (action %0d)",
                                  got.alarm_slot, want.alarm_slot, want.action));
      end
      if (got.chime_track !== want.chime_track) begin
        report_mismatch($sformatf("chime_track got %0d want %0d (action %0d)",
                                  got.chime_track, want.chime_track, want.action));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("last got %0d want %0d (action %0d)",
                                  got.last, want.last, want.action));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        alarm_slots[i] = '0;
      end
      power_off_armed = 1'b0;
      hour_track      = 8'd0;
      half_track      = 8'd0;
      quarter_track   = 8'd0;
      first_hour      = 5'd0;
      last_hour       = LAST_HOUR_RST;
      expected_actions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOUR_TRACK:    hour_track    = cfg_wdata;
          CFG_HALF_TRACK:    half_track    = cfg_wdata;
          CFG_QUARTER_TRACK: quarter_track = cfg_wdata;
          CFG_FIRST_HOUR:    first_hour    = cfg_wdata[4:0];
          CFG_LAST_HOUR:     last_hour     = cfg_wdata[4:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        compare_action(out_data);
      end
      if (in_valid && !in_stall) begin
        predict_actions(in_data);
      end
    end
    mismatches      <= mismatch_count;
    actions_pending <= expected_actions.size();
    actions_checked <= checked_count;
  end

endmodule

// File: bench/weekday_alarm_matcher_tb.sv
`timescale 1ns / 1ps
// top of the weekday alarm matcher bench: clock, reset, stimulus, output stalls and verdict
// depends on wam_pkg, weekday_alarm_matcher and weekday_alarm_matcher_checker

module weekday_alarm_matcher_tb;
  import wam_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [2:0] SCH_DAILY     = 3'd2;
  localparam logic [2:0] SCH_SPARE     = 3'd7;

  localparam int MINUTES_PER_HOUR = 60;
  localparam int MINUTES_PER_DAY  = 1440;
  localparam int RANDOM_ITEMS     = 85;
  localparam int SETTLE_CYCLES    = ALARM_SLOTS + 8;
  localparam int HOLD_CYCLES      = 60;
  localparam int MAX_GAP          = 12;
  localparam int QUIET_LIMIT      = 2000;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  wam_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  wam_out_t   out_data;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  logic idle_on       = 1'b1;
  int   hold_requests = 0;
  int   quiet_cycles  = 0;
  int   mismatches;
  int   actions_pending;
  int   actions_checked;
  int   writes_sent   = 0;
  int   ticks_sent    = 0;
  int   fades_sent    = 0;
  int   ignored_sent  = 0;
  int   settings_used = 0;
  int   note_hour   [ALARM_SLOTS];
  int   note_minute [ALARM_SLOTS];
  int   note_lead   [ALARM_SLOTS];

  weekday_alarm_matcher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  weekday_alarm_matcher_checker alarm_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .actions_pending (actions_pending),
    .actions_checked (actions_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request from the stimulus
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("weekday_alarm_matcher_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic wam_in_t tick_at(input int h, input int m, input int sec, input int wd);
    wam_in_t item;
    item         = '0;
    item.mode    = MODE_TICK;
    item.hour    = 5'(h);
    item.minute  = 6'(m);
    item.second  = 6'(sec);
    item.weekday = 3'(wd);
    return item;
  endfunction

  function automatic wam_in_t slot_write(input int idx, input logic [2:0] sched, input int h,
                                         input int m, input bit sound, input bit sun,
                                         input int lead, input bit dusk, input bit poff);
    wam_in_t item;
    item                = '0;
    item.mode           = MODE_WRITE;
    item.entry_index    = 3'(idx);
    item.schedule       = sched;
    item.hour           = 5'(h);
    item.minute         = 6'(m);
    item.has_sound      = sound;
    item.sunrise_on     = sun;
    item.sunrise_lead   = 11'(lead);
    item.dusk_on        = dusk;
    item.dusk_power_off = poff;
    return item;
  endfunction

  function automatic wam_in_t plain_item(input logic [1:0] mode);
    wam_in_t item;
    item      = '0;
    item.mode = mode;
    return item;
  endfunction

  task automatic send_item(input wam_in_t item);
    int gap;
    gap = 0;
    while (idle_on && gap < MAX_GAP && $urandom_range(0, 99) < 30) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.mode == MODE_WRITE) begin
      writes_sent++;
      note_hour[item.entry_index]   = item.hour;
      note_minute[item.entry_index] = item.minute;
      note_lead[item.entry_index]   = item.sunrise_lead;
    end else if (item.mode == MODE_TICK && item.second == 6'd0) begin
      ticks_sent++;
    end else if (item.mode == MODE_FADE) begin
      fades_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  // wait for the block to drain, then load all five chime registers
  task automatic write_settings(input logic [7:0] hour_t, half_t, quarter_t,
                                input logic [4:0] first_h, last_h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (actions_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOUR_TRACK;
    cfg_wdata <= hour_t;
    @(posedge clk);
    cfg_index <= CFG_HALF_TRACK;
    cfg_wdata <= half_t;
    @(posedge clk);
    cfg_index <= CFG_QUARTER_TRACK;
    cfg_wdata <= quarter_t;
    @(posedge clk);
    cfg_index <= CFG_FIRST_HOUR;
    cfg_wdata <= 8'(first_h);
    @(posedge clk);
    cfg_index <= CFG_LAST_HOUR;
    cfg_wdata <= 8'(last_h);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    wam_in_t     item;
    logic [63:0] raw;
    int          pick;
    int          slot;
    int          total;
    int          effective;
    int          phase;
    bit          held;
    logic [4:0]  first_h;

    effective = 0;
    phase     = 0;
    held      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // chimes are off after reset, so a full-hour tick stays silent
    send_item(tick_at(0, 0, 0, 0));
    write_settings(8'd1, 8'd2, 8'd3, 5'd0, LAST_HOUR_RST);

    send_item(slot_write(0, SCH_DAILY, 7, 30, 1, 1, 30, 1, 1));
    send_item(tick_at(7, 0, 0, 1));
    send_item(tick_at(7, 30, 0, 1));
    send_item(plain_item(MODE_FADE));
    send_item(plain_item(MODE_FADE));
    send_item(slot_write(1, SCH_ONCE, 6, 15, 1, 0, 0, 1, 0));
    send_item(slot_write(7, SCH_WEEKEND, 6, 15, 1, 0, 0, 0, 0));
    send_item(tick_at(6, 15, 0, 6));
    send_item(plain_item(MODE_FADE));
    // one-time slot is off now, the weekend slot takes over
    send_item(tick_at(6, 15, 0, 6));
    send_item(tick_at(6, 15, 0, 3));
    // sunrise a day ahead: lands on sunday from saturday, on monday from weekday seven
    send_item(slot_write(2, SCH_WORK, 23, 50, 0, 1, 1439, 0, 0));
    send_item(tick_at(23, 51, 0, 6));
    send_item(tick_at(23, 51, 0, 7));
    // unknown schedule with out-of-range time and the largest lead
    send_item(slot_write(3, SCH_SPARE, 31, 63, 1, 1, 2047, 1, 1));
    send_item(tick_at(31, 63, 0, 7));
    send_item(tick_at(7, 30, 59, 1));
    send_item(plain_item(MODE_RESERVED));
    send_item(tick_at(12, 30, 0, 2));
    send_item(tick_at(12, 45, 0, 4));
    send_item(plain_item(MODE_FADE));
    // sunrise of one slot together with sound and dusk of another
    send_item(slot_write(4, SCH_DAILY, 8, 0, 1, 0, 0, 1, 0));
    send_item(slot_write(5, SCH_DAILY, 8, 10, 0, 1, 10, 0, 0));
    send_item(tick_at(8, 0, 0, 3));
    send_item(slot_write(0, SCH_OFF, 7, 30, 1, 1, 30, 1, 1));
    send_item(tick_at(7, 30, 0, 1));

    write_settings(8'd255, 8'd255, 8'd255, 5'd7, 5'd20);

    while (effective < RANDOM_ITEMS) begin
      idle_on <= !(effective >= 25 && effective < 50);
      if (effective >= 15 && !held) begin
        held = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      if (effective >= 30 && phase == 0) begin
        phase = 1;
        write_settings(8'd0, 8'd255, 8'd128, 5'd0, 5'd0);
      end else if (effective >= 55 && phase == 1) begin
        phase = 2;
        first_h = 5'($urandom_range(0, 24));
        write_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), first_h,
                       5'($urandom_range(int'(first_h), 24)));
      end else if (effective >= 72 && phase == 2) begin
        phase = 3;
        write_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), 5'd24, 5'd24);
      end

      raw  = {$urandom, $urandom};
      item = raw[$bits(wam_in_t)-1:0];
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, ALARM_SLOTS - 1);
      if (pick < 22) begin
        item.mode = MODE_WRITE;
        if ($urandom_range(0, 99) < 85) begin
          item.hour     = 5'($urandom_range(0, 23));
          item.minute   = 6'($urandom_range(0, 59));
          item.schedule = 3'($urandom_range(1, 4));
          item.sunrise_lead = ($urandom_range(0, 99) < 80) ? 11'($urandom_range(0, 180))
                                                            : 11'($urandom_range(0, 1439));
        end
      end else if (pick < 32) begin
        item.mode = MODE_FADE;
      end else if (pick < 35) begin
        item.mode = MODE_RESERVED;
      end else begin
        item.mode = MODE_TICK;
        if (pick < 60) begin
          item.hour   = 5'(note_hour[slot]);
          item.minute = 6'(note_minute[slot]);
          item.second = 6'd0;
        end else if (pick < 75) begin
          // aim at the sunrise of a slot: its time moved back by its lead
          total = note_hour[slot] * MINUTES_PER_HOUR + note_minute[slot] - note_lead[slot];
          while (total < 0) total += MINUTES_PER_DAY;
          item.hour   = 5'(total / MINUTES_PER_HOUR);
          item.minute = 6'(total % MINUTES_PER_HOUR);
          item.second = 6'd0;
        end else if (pick < 85) begin
          item.hour   = 5'($urandom_range(0, 24));
          item.minute = 6'(int'(MIN_QUARTER) * $urandom_range(0, 3));
          item.second = 6'd0;
        end
      end
      send_item(item);
      if (!(item.mode == MODE_RESERVED || (item.mode == MODE_TICK && item.second != 6'd0))) begin
        effective++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (actions_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d slot writes, %0d acting ticks, %0d fade events, %0d ignored items",
             writes_sent, ticks_sent, fades_sent, ignored_sent);
    $display("%0d chime settings, one long output hold-off, %0d actions checked, %0d mismatches",
             settings_used, actions_checked, mismatches);
    if (mismatches == 0) begin
      $display("weekday_alarm_matcher_tb: PASS");
    end else begin
      $display("weekday_alarm_matcher_tb: FAIL");
    end
    $finish;
  end

endmodule
